@@ sv/xeu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xeu_pkg
// types, constants and entity tables for the xml entity decoder
// ----------------------------------------------------------------------------
package xeu_pkg;

    localparam int MAX_OUT = 6;
    localparam int CNT_W   = 3;

    localparam logic [7:0] AMP_CH  = 8'h26;
    localparam logic [7:0] SEMI_CH = 8'h3B;
    localparam logic [7:0] L_CH    = 8'h6C;
    localparam logic [7:0] G_CH    = 8'h67;
    localparam logic [7:0] A_CH    = 8'h61;
    localparam logic [7:0] Q_CH    = 8'h71;

    localparam logic [1:0] KIND_LT   = 2'd0;
    localparam logic [1:0] KIND_GT   = 2'd1;
    localparam logic [1:0] KIND_AMP  = 2'd2;
    localparam logic [1:0] KIND_QUOT = 2'd3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       text_done;
    } out_item_t;

    function automatic logic [CNT_W-1:0] ent_len(input logic [1:0] k);
        logic [CNT_W-1:0] r;
        case (k)
            KIND_LT:   r = 3'd3;
            KIND_GT:   r = 3'd3;
            KIND_AMP:  r = 3'd4;
            KIND_QUOT: r = 3'd5;
            default:   r = 3'd3;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] ent_value(input logic [1:0] k);
        logic [7:0] r;
        case (k)
            KIND_LT:   r = 8'h3C;
            KIND_GT:   r = 8'h3E;
            KIND_AMP:  r = 8'h26;
            KIND_QUOT: r = 8'h22;
            default:   r = 8'h3C;
        endcase
        return r;
    endfunction

    // letter at position pos of an entity name, ';' closes it
    function automatic logic [7:0] ent_char(input logic [1:0] k, input logic [CNT_W-1:0] pos);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            KIND_LT:
            begin
                case (pos)
                    3'd0:    r = L_CH;
                    3'd1:    r = 8'h74;
                    3'd2:    r = SEMI_CH;
                    default: r = 8'h00;
                endcase
            end
            KIND_GT:
            begin
                case (pos)
                    3'd0:    r = G_CH;
                    3'd1:    r = 8'h74;
                    3'd2:    r = SEMI_CH;
                    default: r = 8'h00;
                endcase
            end
            KIND_AMP:
            begin
                case (pos)
                    3'd0:    r = A_CH;
                    3'd1:    r = 8'h6D;
                    3'd2:    r = 8'h70;
                    3'd3:    r = SEMI_CH;
                    default: r = 8'h00;
                endcase
            end
            KIND_QUOT:
            begin
                case (pos)
                    3'd0:    r = Q_CH;
                    3'd1:    r = 8'h75;
                    3'd2:    r = 8'h6F;
                    3'd3:    r = 8'h74;
                    3'd4:    r = SEMI_CH;
                    default: r = 8'h00;
                endcase
            end
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // byte j of a held run: the ampersand, then the held letters
    function automatic logic [7:0] held_char(input logic [1:0] k, input logic [CNT_W-1:0] j);
        logic [7:0] r;
        if (j == 3'd0)
        begin
            r = AMP_CH;
        end
        else
        begin
            r = ent_char(k, j - 3'd1);
        end
        return r;
    endfunction

    // held letters, bounded by the name length less the closing ';'
    function automatic logic [CNT_W-1:0] held_count(input logic [1:0] k,
                                                    input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] lim;
        lim = ent_len(k) - 3'd1;
        return (c > lim) ? lim : c;
    endfunction

endpackage
`default_nettype wire

@@ sv/xml_entity_unescape.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xml_entity_unescape
// streaming decoder for &lt; &gt; &amp; &quot;, one byte per request
// ----------------------------------------------------------------------------
// the first result is registered and is valid in the cycle after the request is accepted
// output: one result per cycle while dst_ready is high; the next request is taken in the
//   same cycle as the last result of the current one
// requests that only hold bytes produce no result
// reset: matcher idle, result buffer empty
module xml_entity_unescape
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 src_valid,
    output logic                      src_ready,
    input  wire xeu_pkg::in_item_t    src_item,
    output logic                      dst_valid,
    input  wire logic                 dst_ready,
    output xeu_pkg::out_item_t        dst_item
);
    import xeu_pkg::*;

    logic                    matching_reg, matching_next;
    logic [1:0]              kind_reg, kind_next;
    logic [CNT_W-1:0]        count_reg, count_next;

    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [7:0]              buf_reg [MAX_OUT];
    logic [7:0]              buf_next [MAX_OUT];
    logic                    eot_reg;

    logic                    accept;
    logic                    take;

    logic [7:0]              b;
    logic                    flush_before;
    logic                    ev;
    logic [7:0]              e;
    logic [CNT_W-1:0]        len1;
    logic [CNT_W-1:0]        len2;
    logic [CNT_W-1:0]        total;
    logic [CNT_W-1:0]        slot;
    logic [CNT_W-1:0]        j;
    logic                    first_hit;
    logic [1:0]              first_kind;
    logic                    hit;

    assign take      = dst_valid && dst_ready;
    assign src_ready = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && dst_ready);
    assign accept    = src_valid && src_ready;

    assign dst_valid          = (cnt_reg != 3'd0);
    assign dst_item.out_byte  = buf_reg[0];
    assign dst_item.run_last  = (cnt_reg == 3'd1);
    assign dst_item.text_done = (cnt_reg == 3'd1) && eot_reg;

    always_comb
    begin
        b             = src_item.in_byte;
        flush_before  = 1'b0;
        ev            = 1'b0;
        e             = b;
        matching_next = matching_reg;
        kind_next     = kind_reg;
        count_next    = count_reg;
        first_hit     = 1'b1;
        first_kind    = KIND_LT;
        hit           = 1'b0;

        case (b)
            L_CH:    first_kind = KIND_LT;
            G_CH:    first_kind = KIND_GT;
            A_CH:    first_kind = KIND_AMP;
            Q_CH:    first_kind = KIND_QUOT;
            default: first_hit  = 1'b0;
        endcase

        if (matching_reg && (count_reg != 3'd0))
        begin
            hit = (count_reg < ent_len(kind_reg)) && (ent_char(kind_reg, count_reg) == b);
        end

        if (matching_reg && (count_reg == 3'd0) && first_hit)
        begin
            kind_next  = first_kind;
            count_next = 3'd1;
        end
        else if (matching_reg && hit)
        begin
            if (b == SEMI_CH)
            begin
                ev            = 1'b1;
                e             = ent_value(kind_reg);
                matching_next = 1'b0;
                kind_next     = KIND_LT;
                count_next    = 3'd0;
            end
            else
            begin
                count_next = count_reg + 3'd1;
            end
        end
        else
        begin
            // idle handling, after a flush of the broken run if one was held
            flush_before = matching_reg;
            kind_next    = KIND_LT;
            count_next   = 3'd0;
            if (b == AMP_CH)
            begin
                matching_next = 1'b1;
            end
            else
            begin
                matching_next = 1'b0;
                ev            = 1'b1;
            end
        end

        len1  = flush_before ? (3'd1 + held_count(kind_reg, count_reg)) : 3'd0;
        len2  = (src_item.end_of_text && matching_next)
                ? (3'd1 + held_count(kind_next, count_next)) : 3'd0;
        total = len1 + {2'b00, ev} + len2;

        for (int i = 0; i < MAX_OUT; i++)
        begin
            slot = CNT_W'(i);
            j    = slot - len1 - {2'b00, ev};
            if (slot < len1)
            begin
                buf_next[i] = held_char(kind_reg, slot);
            end
            else if (ev && (slot == len1))
            begin
                buf_next[i] = e;
            end
            else
            begin
                buf_next[i] = held_char(kind_next, j);
            end
        end

        if (src_item.end_of_text)
        begin
            matching_next = 1'b0;
            kind_next     = KIND_LT;
            count_next    = 3'd0;
        end

        if (accept)
        begin
            cnt_next = total;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - 3'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matching_reg <= 1'b0;
            kind_reg     <= KIND_LT;
            count_reg    <= 3'd0;
            cnt_reg      <= 3'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                matching_reg <= matching_next;
                kind_reg     <= kind_next;
                count_reg    <= count_next;
            end
        end
    end

    // result buffer shifts toward slot zero as results are taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            eot_reg <= src_item.end_of_text;
            for (int i = 0; i < MAX_OUT; i++)
            begin
                buf_reg[i] <= buf_next[i];
            end
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_OUT - 1; i++)
            begin
                buf_reg[i] <= buf_reg[i+1];
            end
        end
    end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// stream test for the xml entity decoder
// ----------------------------------------------------------------------------
// Bytes of escaped text are sent in bursts while the output side stalls in
// changing patterns. A local decoder tracks the held ampersand run and works
// out the unescaped bytes. Each result is compared with the oldest expected
// one. A directed part covers plain bytes, every entity and the longest
// broken run. Random texts with full, partial and broken entities follow.
// ----------------------------------------------------------------------------
module tb_top;
    import xeu_pkg::*;

    localparam int TOTAL_REQUESTS = 470;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 10;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      src_valid = 1'b0;
    logic      src_ready;
    in_item_t  src_item = '0;
    logic      dst_valid;
    logic      dst_ready = 1'b0;
    out_item_t dst_item;

    // decoder state mirror
    logic       held_active = 1'b0;
    logic [1:0] held_kind = KIND_LT;
    logic [2:0] held_letters = 3'd0;

    out_item_t  expected_out[$];
    logic [7:0] decoded_bytes[$];
    logic [7:0] text_bytes[$];

    int sent_count = 0;
    int burst_left = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int rx_mode = 0;
    int rx_phase_left = 0;

    xml_entity_unescape DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_item  (src_item),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_item  (dst_item)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // entity name after the ampersand, closed by ';'
    function automatic string entity_name(input logic [1:0] kind);
        string s;
        case (kind)
            KIND_LT:   s = "lt;";
            KIND_GT:   s = "gt;";
            KIND_AMP:  s = "amp;";
            default:   s = "quot;";
        endcase
        return s;
    endfunction

    function automatic int name_length(input logic [1:0] kind);
        string s;
        s = entity_name(kind);
        return s.len();
    endfunction

    function automatic logic [7:0] entity_char(input logic [1:0] kind);
        logic [7:0] c;
        case (kind)
            KIND_LT:   c = "<";
            KIND_GT:   c = ">";
            KIND_AMP:  c = "&";
            default:   c = "\"";
        endcase
        return c;
    endfunction

    function automatic logic [7:0] name_letter(input logic [1:0] kind, input int pos);
        string s;
        s = entity_name(kind);
        return (pos < s.len()) ? s[pos] : 8'h00;
    endfunction

    task automatic flush_held_run();
        for (int i = 0; i <= held_letters; i++)
        begin
            decoded_bytes.push_back((i == 0) ? AMP_CH : name_letter(held_kind, i - 1));
        end
        held_active = 1'b0;
        held_kind = KIND_LT;
        held_letters = 3'd0;
    endtask

    task automatic take_idle_byte(input logic [7:0] b);
        if (b == AMP_CH)
        begin
            held_active = 1'b1;
            held_kind = KIND_LT;
            held_letters = 3'd0;
        end
        else
        begin
            decoded_bytes.push_back(b);
        end
    endtask

    task automatic predict_request(input in_item_t req);
        logic [7:0] b;
        logic       found;
        out_item_t  item;
        b = req.in_byte;
        found = 1'b0;
        decoded_bytes.delete();
        if (!held_active)
        begin
            take_idle_byte(b);
        end
        else if (held_letters == 3'd0)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (!found && name_letter(k[1:0], 0) == b)
                begin
                    held_kind = k[1:0];
                    held_letters = 3'd1;
                    found = 1'b1;
                end
            end
            if (!found)
            begin
                flush_held_run();
                take_idle_byte(b);
            end
        end
        else if (held_letters < name_length(held_kind)
                 && name_letter(held_kind, held_letters) == b)
        begin
            if (b == SEMI_CH)
            begin
                decoded_bytes.push_back(entity_char(held_kind));
                held_active = 1'b0;
                held_kind = KIND_LT;
                held_letters = 3'd0;
            end
            else
            begin
                held_letters = held_letters + 3'd1;
            end
        end
        else
        begin
            flush_held_run();
            take_idle_byte(b);
        end
        if (req.end_of_text && held_active)
        begin
            flush_held_run();
        end
        for (int i = 0; i < decoded_bytes.size(); i++)
        begin
            item.out_byte  = decoded_bytes[i];
            item.run_last  = (i == decoded_bytes.size() - 1);
            item.text_done = item.run_last && req.end_of_text;
            expected_out.push_back(item);
        end
    endtask

    task automatic send_request(input logic [7:0] b, input logic eot);
        in_item_t req;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap != 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        req.in_byte = b;
        req.end_of_text = eot;
        src_item <= req;
        src_valid <= 1'b1;
        @(posedge clk);
        while (!src_ready)
        begin
            @(posedge clk);
        end
        predict_request(req);
        sent_count = sent_count + 1;
    endtask

    task automatic append_string(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_bytes.push_back(s[i]);
        end
    endtask

    task automatic send_text(input logic eot_at_end);
        for (int i = 0; i < text_bytes.size(); i++)
        begin
            send_request(text_bytes[i], eot_at_end && (i == text_bytes.size() - 1));
        end
        text_bytes.delete();
    endtask

    task automatic test_plain_bytes();
        text_bytes.push_back(8'h00);
        text_bytes.push_back(8'hFF);
        send_text(1'b1);
    endtask

    task automatic test_entities();
        append_string("&lt;&gt;&amp;&quot;");
        send_text(1'b1);
    endtask

    // longest output burst: full held run, then a new ampersand flushed at the end
    task automatic test_broken_match();
        append_string("&quot&");
        send_text(1'b1);
    endtask

    task automatic test_random_text();
        int         tokens;
        int         pick;
        int         n;
        logic [1:0] kind;
        string      letters;
        letters = "ltgampquo;&";
        while (sent_count < TOTAL_REQUESTS)
        begin
            tokens = $urandom_range(1, 12);
            for (int t = 0; t < tokens; t++)
            begin
                pick = $urandom_range(0, 99);
                kind = 2'($urandom_range(0, 3));
                if (pick < 35)
                begin
                    text_bytes.push_back(8'($urandom_range(0, 255)));
                end
                else if (pick < 60)
                begin
                    text_bytes.push_back(AMP_CH);
                    append_string(entity_name(kind));
                end
                else if (pick < 80)
                begin
                    n = $urandom_range(0, name_length(kind) - 1);
                    text_bytes.push_back(AMP_CH);
                    for (int i = 0; i < n; i++)
                    begin
                        text_bytes.push_back(name_letter(kind, i));
                    end
                    case ($urandom_range(0, 2))
                        0:       text_bytes.push_back(AMP_CH);
                        1:       text_bytes.push_back(SEMI_CH);
                        default: text_bytes.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
                else if (pick < 90)
                begin
                    text_bytes.push_back(AMP_CH);
                end
                else
                begin
                    text_bytes.push_back(letters[$urandom_range(0, letters.len() - 1)]);
                end
            end
            send_text(1'b1);
        end
    endtask

    // output side: stall pattern changes every phase
    always @(posedge clk)
    begin
        if (rx_phase_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_phase_left <= $urandom_range(20, 200);
        end
        else
        begin
            rx_phase_left <= rx_phase_left - 1;
        end
        case (rx_mode)
            0:       dst_ready <= 1'b1;
            1:       dst_ready <= 1'($urandom_range(0, 1));
            2:       dst_ready <= ($urandom_range(0, 3) != 0);
            default: dst_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && dst_valid && dst_ready)
        begin
            if (expected_out.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                begin
                    $display("%0t unexpected result: out_byte=%h run_last=%b text_done=%b",
                             $time, dst_item.out_byte, dst_item.run_last, dst_item.text_done);
                end
            end
            else
            begin
                want = expected_out.pop_front();
                if (dst_item.out_byte !== want.out_byte || dst_item.run_last !== want.run_last
                    || dst_item.text_done !== want.text_done)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                    begin
                        $display("%0t mismatch: expected out_byte=%h run_last=%b text_done=%b,",
                                 $time, want.out_byte, want.run_last, want.text_done);
                        $display("    got out_byte=%h run_last=%b text_done=%b",
                                 dst_item.out_byte, dst_item.run_last, dst_item.text_done);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((src_valid && src_ready) || (dst_valid && dst_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t watchdog: no request or result moved, %0d results outstanding",
                     $time, expected_out.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_entities();
        test_broken_match();
        test_random_text();
        src_valid <= 1'b0;
        while (expected_out.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/xeu_pkg.sv
sv/xml_entity_unescape.sv
tb/tb_top.sv
